// ===== rtl/core/skt_pkg.sv =====
// Shared constants and types for the sorted key/tag table.
// Used by skt_cell, skt_gather, the table and the bench; no dependencies.
package skt_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int TAG_BITS_DEF = 32;
    localparam int KEY_BITS     = 64;
    localparam int GATHER_GROUP = 16;   // cells per first-level gather group

    typedef enum logic [2:0] {
        F_INSERT      = 3'd0,
        F_REMOVE      = 3'd1,
        F_BEGIN_FIRST = 3'd2,
        F_BEGIN_LAST  = 3'd3,
        F_NEXT        = 3'd4,
        F_PREV        = 3'd5
    } t_func;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_DUP      = 3'd1,
        ST_NOTFOUND = 3'd2,
        ST_FULL     = 3'd3,
        ST_END      = 3'd4
    } t_status;

    // broadcast command from the controller to every cell
    typedef struct packed {
        logic cmp_en;   // latch compare flags against the broadcast pair
        logic rd_mode;  // select line means "cell index == read index"
        logic ins;      // shift toward higher index, open a slot
        logic rem;      // shift toward lower index, close a slot
    } t_cell_cmd;

endpackage

// ===== rtl/core/skt_cell.sv =====
// One storage cell of the sorted chain: holds a pair, compares it with the
// broadcast pair and shifts with its neighbors. Depends on skt_pkg.
module skt_cell
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF,
    parameter int POS      = 0
) (
    input  logic                         i_clk,
    input  t_cell_cmd                    i_cmd,
    input  logic [KEY_BITS-1:0]          i_key,
    input  logic [TAG_BITS-1:0]          i_tag,
    input  logic [$clog2(CAPACITY+1)-1:0] i_count,
    input  logic [$clog2(CAPACITY)-1:0]  i_rd_idx,
    input  logic                         i_left_lt,
    input  logic [KEY_BITS-1:0]          i_left_key,
    input  logic [TAG_BITS-1:0]          i_left_tag,
    input  logic [KEY_BITS-1:0]          i_right_key,
    input  logic [TAG_BITS-1:0]          i_right_tag,
    output logic                         o_lt,
    output logic [KEY_BITS-1:0]          o_key,
    output logic [TAG_BITS-1:0]          o_tag,
    output logic                         o_sel
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam logic [CNT_W-1:0] POS_CNT = CNT_W'(POS);
    localparam logic [IDX_W-1:0] POS_IDX = IDX_W'(POS);

    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic                r_lt;
    logic                r_eq;
    logic                w_valid;
    logic                w_key_eq;
    logic                w_less;

    assign w_valid  = POS_CNT < i_count;
    assign w_key_eq = r_key == i_key;
    assign w_less   = ($signed(r_key) < $signed(i_key)) || (w_key_eq && (r_tag < i_tag));

    always_ff @(posedge i_clk) begin
        if (i_cmd.cmp_en) begin
            r_lt <= w_valid && w_less;
            r_eq <= w_valid && w_key_eq && (r_tag == i_tag);
        end
        if (i_cmd.ins && !r_lt) begin
            r_key <= i_left_lt ? i_key : i_left_key;
            r_tag <= i_left_lt ? i_tag : i_left_tag;
        end else if (i_cmd.rem && !r_lt) begin
            r_key <= i_right_key;
            r_tag <= i_right_tag;
        end
    end

    assign o_lt  = r_lt;
    assign o_key = r_key;
    assign o_tag = r_tag;
    // set is unique: the single equal cell is exactly the match position
    assign o_sel = i_cmd.rd_mode ? (POS_IDX == i_rd_idx) : r_eq;

endmodule

// ===== rtl/core/skt_gather.sv =====
// Two-level registered AND-OR collector over the cell row: returns whether
// any cell is selected and the selected cell's data. Depends on skt_pkg.
module skt_gather
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int DATA_W   = KEY_BITS + TAG_BITS_DEF
) (
    input  logic                i_clk,
    input  logic [CAPACITY-1:0] i_sel,
    input  logic [DATA_W-1:0]   i_data [CAPACITY],
    output logic                o_hit,
    output logic [DATA_W-1:0]   o_data
);

    localparam int NGRP = (CAPACITY + GATHER_GROUP - 1) / GATHER_GROUP;

    logic [NGRP-1:0]   n_grp_hit;
    logic [NGRP-1:0]   r_grp_hit;
    logic [DATA_W-1:0] n_grp_data [NGRP];
    logic [DATA_W-1:0] r_grp_data [NGRP];
    logic              n_hit;
    logic [DATA_W-1:0] n_data;
    logic              r_hit;
    logic [DATA_W-1:0] r_data;

    always_comb begin
        int idx;
        for (int g = 0; g < NGRP; g++) begin
            n_grp_hit[g]  = 1'b0;
            n_grp_data[g] = '0;
            for (int j = 0; j < GATHER_GROUP; j++) begin
                idx = g * GATHER_GROUP + j;
                if (idx < CAPACITY) begin
                    n_grp_hit[g]  = n_grp_hit[g] | i_sel[idx];
                    n_grp_data[g] = n_grp_data[g] | (i_data[idx] & {DATA_W{i_sel[idx]}});
                end
            end
        end
    end

    always_comb begin
        n_hit  = 1'b0;
        n_data = '0;
        for (int g = 0; g < NGRP; g++) begin
            n_hit  = n_hit | r_grp_hit[g];
            n_data = n_data | (r_grp_data[g] & {DATA_W{r_grp_hit[g]}});
        end
    end

    always_ff @(posedge i_clk) begin
        r_grp_hit  <= n_grp_hit;
        r_grp_data <= n_grp_data;
        r_hit      <= n_hit;
        r_data     <= n_data;
    end

    assign o_hit  = r_hit;
    assign o_data = r_data;

endmodule

// ===== rtl/core/sorted_key_tag_table.sv =====
// Sorted set of (signed key, tag) pairs held in a shifting row of cells.
// Each word is accepted, then passes the compare, two gather stages and
// the update; a new word is accepted only after the update, and a result
// word still held by the receiver stalls the update stage.
// Reset (sync, active low): table empty, cursor invalid, ascending order,
// output empty. Cell contents are not cleared; only entries below the count
// are ever read.
module sorted_key_tag_table
    import skt_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    // input words
    input  logic                                       i_s_tvalid,
    output logic                                       o_s_tready,
    // [63:0] key, [64+TAG_BITS-1:64] tag, zero pad to bytes
    input  logic [((KEY_BITS+TAG_BITS+7)/8)*8-1:0]     i_s_tdata,
    // [2:0] func
    input  logic [2:0]                                 i_s_tuser,
    // result words
    output logic                                       o_m_tvalid,
    input  logic                                       i_m_tready,
    // [63:0] out_key, then out_tag, then entry_count, zero pad to bytes
    output logic [((KEY_BITS+TAG_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] o_m_tdata,
    // [2:0] status
    output logic [2:0]                                 o_m_tuser,
    // order register: descending
    input  logic                                       i_cfg_valid,
    output logic                                       o_cfg_ready,
    input  logic                                       i_cfg_data
);

    localparam int CNT_W  = $clog2(CAPACITY + 1);
    localparam int IDX_W  = $clog2(CAPACITY);
    localparam int DATA_W = KEY_BITS + TAG_BITS;
    localparam int OUT_W  = ((KEY_BITS + TAG_BITS + CNT_W + 7) / 8) * 8;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    typedef enum logic [2:0] {
        S_IDLE,
        S_CMP,   // cells latch compare flags
        S_G1,    // gather level one
        S_G2,    // gather level two
        S_EXEC   // apply shift, update count and cursor, post result
    } t_state;

    t_state              r_state;
    logic [2:0]          r_func;
    logic [KEY_BITS-1:0] r_key;
    logic [TAG_BITS-1:0] r_tag;
    logic [IDX_W-1:0]    r_rd_idx;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_cursor;
    logic                r_cur_valid;
    logic                r_desc;

    logic                r_out_valid;
    logic [2:0]          r_status;
    logic [KEY_BITS-1:0] r_okey;
    logic [TAG_BITS-1:0] r_otag;
    logic [CNT_W-1:0]    r_ocount;

    logic                w_in_acc;
    logic                w_cfg_acc;
    logic                w_out_free;
    logic                w_finish;
    logic                w_hit;
    logic [DATA_W-1:0]   w_gdata;
    logic [CNT_W-1:0]    n_rd_pos;
    t_cell_cmd           w_cmd;

    logic [CAPACITY-1:0] w_lt;
    logic [CAPACITY-1:0] w_sel;
    logic [KEY_BITS-1:0] w_ckey [CAPACITY];
    logic [TAG_BITS-1:0] w_ctag [CAPACITY];
    logic [DATA_W-1:0]   w_cdata [CAPACITY];

    // config and input never share an edge; config wins
    assign o_cfg_ready = r_state == S_IDLE;
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_finish    = (r_state == S_EXEC) && w_out_free;

    // read position in storage order; cursor counts in configured order
    assign n_rd_pos = r_desc ? (r_count - CNT_W'(1) - r_cursor) : r_cursor;

    // cell row commands
    always_comb begin
        w_cmd.cmp_en  = r_state == S_CMP;
        w_cmd.rd_mode = (r_func == F_NEXT) || (r_func == F_PREV);
        w_cmd.ins     = w_finish && (r_func == F_INSERT) && !w_hit && (r_count != CAP_CNT);
        w_cmd.rem     = w_finish && (r_func == F_REMOVE) && w_hit;
    end

    // the chain: each cell sees its left and right neighbor
    for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
        logic                w_left_lt;
        logic [KEY_BITS-1:0] w_left_key;
        logic [TAG_BITS-1:0] w_left_tag;
        logic [KEY_BITS-1:0] w_right_key;
        logic [TAG_BITS-1:0] w_right_tag;

        if (gi == 0) begin : g_first
            // head of the row: new pair always enters here if nothing is lower
            assign w_left_lt  = 1'b1;
            assign w_left_key = r_key;
            assign w_left_tag = r_tag;
        end else begin : g_mid
            assign w_left_lt  = w_lt[gi-1];
            assign w_left_key = w_ckey[gi-1];
            assign w_left_tag = w_ctag[gi-1];
        end

        if (gi == CAPACITY - 1) begin : g_last
            assign w_right_key = w_ckey[gi];
            assign w_right_tag = w_ctag[gi];
        end else begin : g_inner
            assign w_right_key = w_ckey[gi+1];
            assign w_right_tag = w_ctag[gi+1];
        end

        skt_cell #(
            .CAPACITY (CAPACITY),
            .TAG_BITS (TAG_BITS),
            .POS      (gi)
        ) u_cell (
            .i_clk       (i_clk),
            .i_cmd       (w_cmd),
            .i_key       (r_key),
            .i_tag       (r_tag),
            .i_count     (r_count),
            .i_rd_idx    (r_rd_idx),
            .i_left_lt   (w_left_lt),
            .i_left_key  (w_left_key),
            .i_left_tag  (w_left_tag),
            .i_right_key (w_right_key),
            .i_right_tag (w_right_tag),
            .o_lt        (w_lt[gi]),
            .o_key       (w_ckey[gi]),
            .o_tag       (w_ctag[gi]),
            .o_sel       (w_sel[gi])
        );

        assign w_cdata[gi] = {w_ctag[gi], w_ckey[gi]};
    end

    skt_gather #(
        .CAPACITY (CAPACITY),
        .DATA_W   (DATA_W)
    ) u_gather (
        .i_clk  (i_clk),
        .i_sel  (w_sel),
        .i_data (w_cdata),
        .o_hit  (w_hit),
        .o_data (w_gdata)
    );

    // controller, table count, cursor and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_cursor    <= '0;
            r_cur_valid <= 1'b0;
            r_desc      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && i_m_tready) begin
                r_out_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                r_desc      <= i_cfg_data;
                r_cur_valid <= 1'b0;
                r_cursor    <= '0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_func   <= i_s_tuser;
                        r_key    <= i_s_tdata[KEY_BITS-1:0];
                        r_tag    <= i_s_tdata[DATA_W-1:KEY_BITS];
                        r_rd_idx <= n_rd_pos[IDX_W-1:0];
                        r_state  <= S_CMP;
                    end
                end
                S_CMP: r_state <= S_G1;
                S_G1:  r_state <= S_G2;
                S_G2:  r_state <= S_EXEC;
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_out_valid <= 1'b1;
                        r_status    <= ST_OK;
                        r_okey      <= '0;
                        r_otag      <= '0;
                        r_ocount    <= r_count;
                        unique case (r_func)
                            F_INSERT: begin
                                if (w_hit) begin
                                    r_status <= ST_DUP;
                                end else if (r_count == CAP_CNT) begin
                                    r_status <= ST_FULL;
                                end else begin
                                    r_count     <= r_count + CNT_W'(1);
                                    r_ocount    <= r_count + CNT_W'(1);
                                    r_cur_valid <= 1'b0;
                                    r_cursor    <= '0;
                                end
                            end
                            F_REMOVE: begin
                                if (w_hit) begin
                                    r_count     <= r_count - CNT_W'(1);
                                    r_ocount    <= r_count - CNT_W'(1);
                                    r_cur_valid <= 1'b0;
                                    r_cursor    <= '0;
                                end else begin
                                    r_status <= ST_NOTFOUND;
                                end
                            end
                            F_BEGIN_FIRST, F_BEGIN_LAST: begin
                                if (r_count == '0) begin
                                    r_cur_valid <= 1'b0;
                                    r_cursor    <= '0;
                                end else begin
                                    r_cur_valid <= 1'b1;
                                    r_cursor    <= (r_func == F_BEGIN_FIRST) ? '0
                                                 : r_count - CNT_W'(1);
                                end
                            end
                            F_NEXT, F_PREV: begin
                                if (!r_cur_valid || (r_cursor >= r_count)) begin
                                    r_cur_valid <= 1'b0;
                                    r_cursor    <= '0;
                                    r_status    <= ST_END;
                                end else begin
                                    r_okey <= w_gdata[KEY_BITS-1:0];
                                    r_otag <= w_gdata[DATA_W-1:KEY_BITS];
                                    if (r_func == F_NEXT) begin
                                        // walked off the end of the order
                                        if (r_cursor + CNT_W'(1) >= r_count) begin
                                            r_cur_valid <= 1'b0;
                                            r_cursor    <= '0;
                                        end else begin
                                            r_cursor <= r_cursor + CNT_W'(1);
                                        end
                                    end else begin
                                        if (r_cursor == '0) begin
                                            r_cur_valid <= 1'b0;
                                        end else begin
                                            r_cursor <= r_cursor - CNT_W'(1);
                                        end
                                    end
                                end
                            end
                            default: ;  // unused codes: no operation
                        endcase
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tuser  = r_status;
    assign o_m_tdata  = OUT_W'({r_ocount, r_otag, r_okey});

endmodule

// ===== bench/skt_table_checker.sv =====
// Checker for the sorted key/tag table: watches the input, result and order
// channels, predicts each result word and compares it field by field.
// Depends on skt_pkg for the function and status codes and the widths.
module skt_table_checker
    import skt_pkg::*;
#(
    parameter int CNT_BITS = $clog2(CAPACITY_DEF + 1),
    parameter int S_BITS   = ((KEY_BITS + TAG_BITS_DEF + 7) / 8) * 8,
    parameter int M_BITS   = ((KEY_BITS + TAG_BITS_DEF + CNT_BITS + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [S_BITS-1:0] i_s_tdata,
    input  logic [2:0]        i_s_tuser,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [M_BITS-1:0] i_m_tdata,
    input  logic [2:0]        i_m_tuser,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic              i_cfg_data,
    output int                o_fail_count,
    output int                o_pending
);

    typedef struct packed {
        t_status                 status;
        logic [KEY_BITS-1:0]     key;
        logic [TAG_BITS_DEF-1:0] tag;
        logic [CNT_BITS-1:0]     count;
    } t_table_result;

    // shadow table, always held in ascending order
    logic signed [KEY_BITS-1:0] shadow_key [CAPACITY_DEF];
    logic [TAG_BITS_DEF-1:0]    shadow_tag [CAPACITY_DEF];
    int                         shadow_count;
    int                         cursor_pos;
    bit                         cursor_live;
    bit                         order_desc;

    t_table_result owed_results [$];
    t_table_result want;
    t_table_result got;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit pair_precedes(logic signed [KEY_BITS-1:0] ka,
                                         logic [TAG_BITS_DEF-1:0] ta,
                                         logic signed [KEY_BITS-1:0] kb,
                                         logic [TAG_BITS_DEF-1:0] tb);
        return (ka < kb) || (ka == kb && ta < tb);
    endfunction

    function automatic t_table_result apply_table_op(logic [2:0] op,
                                                     logic signed [KEY_BITS-1:0] key,
                                                     logic [TAG_BITS_DEF-1:0] tag);
        t_table_result res;
        int pos;
        int row;
        bit hit;
        res = '0;
        res.status = ST_OK;
        pos = 0;
        while (pos < shadow_count && pair_precedes(shadow_key[pos], shadow_tag[pos], key, tag))
            pos++;
        hit = (pos < shadow_count) && shadow_key[pos] == key && shadow_tag[pos] == tag;
        case (op)
            F_INSERT: begin
                if (hit) begin
                    res.status = ST_DUP;
                end else if (shadow_count >= CAPACITY_DEF) begin
                    res.status = ST_FULL;
                end else begin
                    for (int i = shadow_count; i > pos; i--) begin
                        shadow_key[i] = shadow_key[i-1];
                        shadow_tag[i] = shadow_tag[i-1];
                    end
                    shadow_key[pos] = key;
                    shadow_tag[pos] = tag;
                    shadow_count++;
                    cursor_live = 1'b0;
                    cursor_pos  = 0;
                end
            end
            F_REMOVE: begin
                if (hit) begin
                    for (int i = pos; i + 1 < shadow_count; i++) begin
                        shadow_key[i] = shadow_key[i+1];
                        shadow_tag[i] = shadow_tag[i+1];
                    end
                    shadow_count--;
                    cursor_live = 1'b0;
                    cursor_pos  = 0;
                end else begin
                    res.status = ST_NOTFOUND;
                end
            end
            F_BEGIN_FIRST, F_BEGIN_LAST: begin
                if (shadow_count == 0) begin
                    cursor_live = 1'b0;
                    cursor_pos  = 0;
                end else begin
                    cursor_live = 1'b1;
                    cursor_pos  = (op == F_BEGIN_FIRST) ? 0 : shadow_count - 1;
                end
            end
            F_NEXT, F_PREV: begin
                if (!cursor_live || cursor_pos >= shadow_count) begin
                    cursor_live = 1'b0;
                    cursor_pos  = 0;
                    res.status  = ST_END;
                end else begin
                    // cursor counts in the configured order; storage is ascending
                    row = order_desc ? shadow_count - 1 - cursor_pos : cursor_pos;
                    res.key = shadow_key[row];
                    res.tag = shadow_tag[row];
                    if (op == F_NEXT) begin
                        cursor_pos++;
                        if (cursor_pos >= shadow_count) begin
                            cursor_live = 1'b0;
                            cursor_pos  = 0;
                        end
                    end else if (cursor_pos == 0) begin
                        cursor_live = 1'b0;
                    end else begin
                        cursor_pos--;
                    end
                end
            end
            default: ;
        endcase
        res.count = CNT_BITS'(shadow_count);
        return res;
    endfunction

    task automatic check_field(string name, logic [63:0] exp_val, logic [63:0] act_val);
        if (exp_val !== act_val) begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
            o_fail_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            shadow_count = 0;
            cursor_pos   = 0;
            cursor_live  = 1'b0;
            order_desc   = 1'b0;
            owed_results.delete();
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.status = t_status'(i_m_tuser);
                got.key    = i_m_tdata[KEY_BITS-1:0];
                got.tag    = i_m_tdata[KEY_BITS +: TAG_BITS_DEF];
                got.count  = i_m_tdata[KEY_BITS+TAG_BITS_DEF +: CNT_BITS];
                if (owed_results.size() == 0) begin
                    $display("%0t: result word with none expected, actual %h", $time, got);
                    o_fail_count++;
                end else begin
                    want = owed_results.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("out_key", want.key, got.key);
                    check_field("out_tag", 64'(want.tag), 64'(got.tag));
                    check_field("entry_count", 64'(want.count), 64'(got.count));
                end
            end
            // any order write drops the cursor
            if (i_cfg_valid && i_cfg_ready) begin
                order_desc  = i_cfg_data;
                cursor_live = 1'b0;
                cursor_pos  = 0;
            end
            if (i_s_tvalid && i_s_tready)
                owed_results.push_back(apply_table_op(i_s_tuser, i_s_tdata[KEY_BITS-1:0],
                                                      i_s_tdata[KEY_BITS +: TAG_BITS_DEF]));
        end
        o_pending = owed_results.size();
    end

endmodule

// ===== bench/sorted_key_tag_table_test.sv =====
// Top of the sorted key/tag table bench: clock, reset, stimulus and verdict.
// Depends on skt_pkg, sorted_key_tag_table and skt_table_checker.
module sorted_key_tag_table_test;
    import skt_pkg::*;

    localparam int CNT_BITS    = $clog2(CAPACITY_DEF + 1);
    localparam int S_BITS      = ((KEY_BITS + TAG_BITS_DEF + 7) / 8) * 8;
    localparam int M_BITS      = ((KEY_BITS + TAG_BITS_DEF + CNT_BITS + 7) / 8) * 8;
    // cycles with no word moving on any channel before the run is called hung
    localparam int STALL_LIMIT = 2000;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_s_tvalid  = 1'b0;
    logic              o_s_tready;
    logic [S_BITS-1:0] i_s_tdata   = '0;   // [63:0] key, [95:64] tag
    logic [2:0]        i_s_tuser   = '0;   // [2:0] func
    logic              o_m_tvalid;
    logic              i_m_tready  = 1'b0;
    logic [M_BITS-1:0] o_m_tdata;          // [63:0] out_key, [95:64] out_tag, [104:96] count
    logic [2:0]        o_m_tuser;          // [2:0] status
    logic              i_cfg_valid = 1'b0;
    logic              o_cfg_ready;
    logic              i_cfg_data  = 1'b0;

    int fail_count;
    int pending;
    int quiet_cycles = 0;
    int words_sent   = 0;
    // idle percentages of the sender and the receiver
    int send_gap_pct = 0;
    int recv_gap_pct = 0;

    logic [63:0] keep_key;
    logic [31:0] keep_tag;

    // keys that collide often, plus both ends of the signed range
    logic [63:0] key_pool [12] = '{
        64'h8000_0000_0000_0000, 64'h8000_0000_0000_0001, 64'hFFFF_FFFF_0000_0000,
        64'hFFFF_FFFF_FFFF_FFFF, 64'h0, 64'h1, 64'h2, 64'hFF, 64'h1_0000_0000,
        64'h100_0000_0007, 64'h7FFF_FFFF_FFFF_FFFE, 64'h7FFF_FFFF_FFFF_FFFF
    };
    logic [31:0] tag_pool [5] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};

    sorted_key_tag_table dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data)
    );

    skt_table_checker u_table_check (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .i_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .i_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .i_m_tdata   (o_m_tdata),
        .i_m_tuser   (o_m_tuser),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .o_fail_count(fail_count),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side back-pressure, redrawn every cycle
    always @(negedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_gap_pct);
    end

    // hang detector: counts cycles in which no word moves anywhere
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    function automatic logic [63:0] pick_key();
        if ($urandom_range(9) < 7)
            return key_pool[$urandom_range(11)];
        return {$urandom, $urandom};
    endfunction

    function automatic logic [31:0] pick_tag();
        if ($urandom_range(3) != 0)
            return tag_pool[$urandom_range(4)];
        return $urandom;
    endfunction

    // One input word. Valid is left high after acceptance; the next call
    // either keeps it high with new data or drops it for a gap, so valid
    // never gets two assignments at one edge.
    task automatic send_word(logic [2:0] op, logic [63:0] key, logic [31:0] tag);
        @(negedge i_clk);
        while ($urandom_range(99) < send_gap_pct) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {tag, key};
        i_s_tuser  <= op;
        do @(posedge i_clk); while (!o_s_tready);
        words_sent++;
    endtask

    // stop sending and wait for every owed result, then let the pipe settle
    task automatic drain();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (8) @(negedge i_clk);
    endtask

    // order register write, only with the table idle
    task automatic write_order(logic desc);
        drain();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= desc;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed traffic: inserts and removes over colliding pairs,
    // cursor walks that start with a begin, and occasional raw noise words.
    task automatic random_burst(int target);
        int first_word;
        int roll;
        int steps;
        bit from_front;
        bit flip;
        first_word = words_sent;
        while (words_sent - first_word < target) begin
            roll = $urandom_range(99);
            if (roll < 36) begin
                send_word(F_INSERT, pick_key(), pick_tag());
            end else if (roll < 62) begin
                send_word(F_REMOVE, pick_key(), pick_tag());
            end else if (roll < 90) begin
                from_front = 1'($urandom_range(1));
                send_word(from_front ? F_BEGIN_FIRST : F_BEGIN_LAST, {$urandom, $urandom},
                          $urandom);
                steps = $urandom_range(1, 12);
                repeat (steps) begin
                    flip = ($urandom_range(4) == 0);
                    send_word((from_front != flip) ? F_NEXT : F_PREV, {$urandom, $urandom},
                              $urandom);
                end
            end else begin
                send_word(3'($urandom_range(7)), {$urandom, $urandom}, $urandom);
            end
        end
    endtask

    initial begin
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        send_gap_pct = 25;
        recv_gap_pct = 47;
        write_order(1'b0);

        // empty table: walks end at once, begin leaves the cursor invalid
        send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_PREV, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(F_BEGIN_FIRST, 64'h0, 32'h0);
        send_word(F_BEGIN_LAST, 64'h0, 32'h0);
        send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_REMOVE, 64'h0, 32'h0);             // missing pair
        // extremes of key and tag, equal keys split by tag
        send_word(F_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(F_INSERT, 64'h8000_0000_0000_0000, 32'h0);
        send_word(F_INSERT, 64'h0, 32'h5);
        send_word(F_INSERT, 64'h0, 32'h4);
        send_word(F_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
        send_word(F_INSERT, 64'h0, 32'h5);             // duplicate, ignored
        // full forward walk runs off the end
        send_word(F_BEGIN_FIRST, 64'h0, 32'h0);
        repeat (6) send_word(F_NEXT, 64'h0, 32'h0);
        // backward walk cut short by an insert
        send_word(F_BEGIN_LAST, 64'h0, 32'h0);
        send_word(F_PREV, 64'h0, 32'h0);
        send_word(F_INSERT, 64'h1, 32'h1);
        send_word(F_PREV, 64'h0, 32'h0);
        // unused codes do nothing
        send_word(3'd6, 64'hA5A5_5A5A_FFFF_0000, 32'h1234_5678);
        send_word(3'd7, 64'h5A5A_A5A5_0000_FFFF, 32'hEDCB_A987);
        send_word(F_REMOVE, 64'h8000_0000_0000_0000, 32'h0);
        send_word(F_REMOVE, 64'h8000_0000_0000_0000, 32'h0);

        // reversed order: first is the largest pair, previous runs off the front
        write_order(1'b1);
        send_word(F_BEGIN_FIRST, 64'h0, 32'h0);
        repeat (3) send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_BEGIN_LAST, 64'h0, 32'h0);
        send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_BEGIN_FIRST, 64'h0, 32'h0);
        repeat (2) send_word(F_PREV, 64'h0, 32'h0);

        random_burst(28);

        send_gap_pct = 47;
        recv_gap_pct = 25;
        write_order(1'b0);
        random_burst(28);

        send_gap_pct = 0;
        recv_gap_pct = 0;
        write_order(1'b1);
        random_burst(28);

        // fill to capacity, then duplicate and overflow on the full table
        keep_key = {$urandom, $urandom};
        keep_tag = $urandom;
        send_word(F_INSERT, keep_key, keep_tag);
        repeat (CAPACITY_DEF + 12) send_word(F_INSERT, {$urandom, $urandom}, $urandom);
        send_word(F_INSERT, keep_key, keep_tag);
        send_word(F_INSERT, {$urandom, $urandom}, $urandom);
        send_word(F_BEGIN_LAST, 64'h0, 32'h0);
        repeat (3) send_word(F_PREV, 64'h0, 32'h0);
        // order write mid-walk drops the cursor
        write_order(1'b0);
        send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_BEGIN_FIRST, 64'h0, 32'h0);
        repeat (3) send_word(F_NEXT, 64'h0, 32'h0);
        send_word(F_REMOVE, keep_key, keep_tag);
        send_word(F_INSERT, keep_key, keep_tag);
        send_word(F_INSERT, {$urandom, $urandom}, $urandom);
        send_word(F_REMOVE, ~keep_key, ~keep_tag);

        drain();
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/skt_pkg.sv
rtl/core/skt_cell.sv
rtl/core/skt_gather.sv
rtl/core/sorted_key_tag_table.sv
bench/skt_table_checker.sv
bench/sorted_key_tag_table_test.sv
